@@ hdl/pgb_pkg.sv @@
// Shared types, constants and the tangent table of the point grid binning block.
package pgb_pkg;

   localparam int COORD_W   = 20;
   localparam int RANGE_W   = 19;
   localparam int SQ_W      = 40;
   localparam int SECT_N    = 120;
   localparam int SECT_AW   = 7;
   localparam int TAN_N     = 14;
   localparam int TAN_SHIFT = 20;
   localparam int CALC_STEPS = 20;

   localparam logic [SQ_W-1:0]    NEAR_SQ       = 40'd262144;
   localparam logic [RANGE_W-1:0] MAX_RANGE_RST = 19'd20480;
   localparam logic signed [COORD_W-1:0] CEILING_RST = 20'sd768;
   localparam logic signed [COORD_W-1:0] FLOOR_RST   = -20'sd512;
   localparam logic signed [COORD_W-1:0] OBJECT_RST  = 20'sd128;
   localparam logic [SECT_AW-1:0] SECT_ORIGIN = 7'd60;
   localparam logic [SECT_AW-1:0] SECT_LAST   = 7'd119;
   localparam logic [SECT_AW-1:0] QUAD_LAST   = 7'd29;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_SCAN  = 2'd1,
      OP_MAP   = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_MAX_RANGE = 2'd0,
      CSR_CEILING   = 2'd1,
      CSR_FLOOR     = 2'd2,
      CSR_OBJECT    = 2'd3
   } csr_type;

   typedef enum logic [1:0] {
      KIND_CLEAR,
      KIND_SKIP,
      KIND_SCAN,
      KIND_MAP
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_SQX,
      ST_SQY,
      ST_CALC,
      ST_READ,
      ST_WRITE,
      ST_ZERO
   } state_type;

   typedef struct packed {
      logic [RANGE_W-1:0]        max_range;
      logic signed [COORD_W-1:0] ceiling;
      logic signed [COORD_W-1:0] floor_h;
      logic signed [COORD_W-1:0] object_h;
   } cfg_type;

   typedef struct packed {
      kind_type                  kind;
      logic                      tall;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } item_type;

   typedef struct packed {
      logic                      in_volume;
      logic [4:0]                col;
      logic [4:0]                row;
      logic [SECT_AW-1:0]        sector;
      logic                      updated;
      logic signed [COORD_W-1:0] top;
      logic signed [COORD_W-1:0] bottom;
      logic signed [COORD_W-1:0] top_x;
      logic signed [COORD_W-1:0] top_y;
      logic [RANGE_W-1:0]        nearest;
   } rsp_type;

   // tan(3 deg * (j+1)) scaled by 2^20
   function automatic logic [19:0] tan_lut(input logic [3:0] j);
      logic [19:0] t;
      case (j)
         4'd0:    t = 20'd54953;
         4'd1:    t = 20'd110210;
         4'd2:    t = 20'd166078;
         4'd3:    t = 20'd222882;
         4'd4:    t = 20'd280965;
         4'd5:    t = 20'd340703;
         4'd6:    t = 20'd402511;
         4'd7:    t = 20'd466856;
         4'd8:    t = 20'd534276;
         4'd9:    t = 20'd605396;
         4'd10:   t = 20'd680953;
         4'd11:   t = 20'd761835;
         4'd12:   t = 20'd849120;
         4'd13:   t = 20'd944142;
         default: t = 20'd0;
      endcase
      return t;
   endfunction

endpackage

@@ hdl/pgb_front.sv @@
// Front end: bounds check and classification of points, two-entry item queue.
module pgb_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  pgb_pkg::cfg_type                    cfg,
   input  logic [1:0]                          operation,
   input  logic signed [pgb_pkg::COORD_W-1:0]  x,
   input  logic signed [pgb_pkg::COORD_W-1:0]  y,
   input  logic signed [pgb_pkg::COORD_W-1:0]  z,
   output logic                                q_valid,
   output pgb_pkg::item_type                   q_item,
   input  logic                                q_pop
);
   import pgb_pkg::*;

   item_type          slot_ff [2];
   logic              wr_ptr_ff, rd_ptr_ff;
   logic [1:0]        count_ff;
   item_type          item_in;
   logic              in_box;
   logic signed [COORD_W:0] xe, ye, re;
   logic              push_ok;

   always_comb begin
      xe = (COORD_W+1)'(x);
      ye = (COORD_W+1)'(y);
      re = $signed({2'b00, cfg.max_range});
      in_box = (z < cfg.ceiling) && (z > cfg.floor_h) &&
               (xe < re) && (-xe < re) && (ye < re) && (-ye < re);
      item_in.x    = x;
      item_in.y    = y;
      item_in.z    = z;
      item_in.tall = (z >= cfg.object_h);
      case (op_type'(operation))
         OP_CLEAR: item_in.kind = KIND_CLEAR;
         OP_SCAN:  item_in.kind = in_box ? KIND_SCAN : KIND_SKIP;
         OP_MAP:   item_in.kind = in_box ? KIND_MAP : KIND_SKIP;
         default:  item_in.kind = KIND_SKIP;
      endcase
   end

   assign full    = (count_ff == 2'd2);
   assign q_valid = (count_ff != 2'd0);
   assign q_item  = slot_ff[rd_ptr_ff];
   assign push_ok = push && !full;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push_ok) wr_ptr_ff <= !wr_ptr_ff;
         if (q_pop) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + 2'(push_ok) - 2'(q_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) slot_ff[wr_ptr_ff] <= item_in;
   end

endmodule

@@ hdl/pgb_back.sv @@
// Back end: cell index division, yaw sector, range root, grid and sector updates.
module pgb_back #(
   parameter int GRID_X = 32,
   parameter int GRID_Y = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pgb_pkg::cfg_type     cfg,
   input  logic                 q_valid,
   input  pgb_pkg::item_type    q_item,
   output logic                 q_pop,
   output logic                 init_busy,
   output logic                 out_valid,
   output pgb_pkg::rsp_type     out_data,
   input  logic                 out_pop
);
   import pgb_pkg::*;

   localparam int QBX = $clog2(GRID_X);
   localparam int QBY = $clog2(GRID_Y);
   localparam int NXW = COORD_W + QBX;
   localparam int NYW = COORD_W + QBY;
   localparam int NCELL = 2 * GRID_X * GRID_Y;
   localparam int CAW = $clog2(NCELL);

   typedef struct packed {
      logic                      occ;
      logic signed [COORD_W-1:0] hi;
      logic signed [COORD_W-1:0] lo;
      logic signed [COORD_W-1:0] hx;
      logic signed [COORD_W-1:0] hy;
   } cell_type;

   state_type state_ff, state_in;
   item_type  item_ff;
   logic      init_ff;
   logic [CAW-1:0] sweep_ff;
   logic [4:0]     step_ff;

   logic [SQ_W-1:0] prod_ff, sq_ff, n_ff, r_ff, bit_ff, tprod_ff;
   logic [NXW-1:0]  remx_ff, dsx_ff;
   logic [NYW-1:0]  remy_ff, dsy_ff;
   logic [QBX-1:0]  qx_ff;
   logic [QBY-1:0]  qy_ff;
   logic [COORD_W-1:0] num_ff, den_ff;
   logic [SECT_AW-1:0] base_ff;
   logic lower_ff, eq_ff, origin_ff, negax_ff;
   logic [3:0] cnt_ff;

   logic [SECT_N-1:0]  sec_valid_ff;
   logic [RANGE_W-1:0] fill_ff;
   cell_type           cell_mem [NCELL];
   cell_type           cell_rd_ff;
   logic [RANGE_W-1:0] sec_mem [SECT_N];
   logic [RANGE_W-1:0] sec_rd_ff;

   logic    out_valid_ff;
   rsp_type out_ff;

   // combinational helpers
   logic signed [COORD_W:0] u, v, xr, yr;
   logic [COORD_W-1:0] qa, qb;
   logic [COORD_W-1:0] ax, ay;
   logic [SECT_AW-1:0] qbase;
   logic [SQ_W-1:0]    rb;
   logic [SECT_AW-1:0] sec_raw, sec_idx;
   logic [CAW-1:0]     cell_addr;
   logic               proceed, last_sweep;
   logic [RANGE_W-1:0] cur_dist, new_dist;
   logic [COORD_W-1:0] root;
   logic               sec_upd;
   cell_type           cell_new;
   logic [QBX+4:0]     colw;
   logic [QBY+4:0]     roww;
   logic               cell_we;
   logic [CAW-1:0]     cell_waddr;
   cell_type           cell_wdata;
   rsp_type            rsp_new;

   always_comb begin
      u  = -((COORD_W+1)'(item_ff.x));
      v  = -((COORD_W+1)'(item_ff.y));
      xr = (COORD_W+1)'(item_ff.x) + $signed({2'b00, cfg.max_range});
      yr = (COORD_W+1)'(item_ff.y) + $signed({2'b00, cfg.max_range});
      // magnitudes fit 20 bits unsigned, even for the most negative value
      ax = item_ff.x[COORD_W-1] ? COORD_W'(-item_ff.x) : COORD_W'(item_ff.x);
      ay = item_ff.y[COORD_W-1] ? COORD_W'(-item_ff.y) : COORD_W'(item_ff.y);
      if (u > 0 && v >= 0) begin
         qa = u[COORD_W-1:0];  qb = v[COORD_W-1:0];  qbase = 7'd0;
      end else if (u <= 0 && v > 0) begin
         qa = v[COORD_W-1:0];  qb = COORD_W'(-u);    qbase = 7'd30;
      end else if (u < 0 && v <= 0) begin
         qa = COORD_W'(-u);    qb = COORD_W'(-v);    qbase = 7'd60;
      end else begin
         qa = COORD_W'(-v);    qb = u[COORD_W-1:0];  qbase = 7'd90;
      end
      rb = r_ff + bit_ff;

      if (lower_ff) sec_raw = base_ff + SECT_AW'(cnt_ff) + SECT_AW'(eq_ff);
      else          sec_raw = base_ff + QUAD_LAST - SECT_AW'(cnt_ff);
      if (origin_ff)               sec_idx = SECT_ORIGIN;
      else if (negax_ff)           sec_idx = SECT_LAST;
      else if (sec_raw > SECT_LAST) sec_idx = SECT_LAST;
      else                         sec_idx = sec_raw;

      cell_addr = CAW'(item_ff.kind == KIND_MAP) * CAW'(GRID_X * GRID_Y)
                + CAW'(qx_ff) * CAW'(GRID_Y) + CAW'(qy_ff);

      proceed    = !out_valid_ff || out_pop;
      last_sweep = (sweep_ff == CAW'(NCELL - 1));

      root     = r_ff[COORD_W-1:0];
      cur_dist = sec_valid_ff[sec_idx] ? sec_rd_ff : fill_ff;
      sec_upd  = item_ff.tall && (sq_ff > NEAR_SQ) && ({1'b0, cur_dist} > root);
      new_dist = sec_upd ? root[RANGE_W-1:0] : cur_dist;

      cell_new = cell_rd_ff;
      cell_new.occ = 1'b1;
      if (!cell_rd_ff.occ) begin
         cell_new.hi = item_ff.z;  cell_new.lo = item_ff.z;
         cell_new.hx = item_ff.x;  cell_new.hy = item_ff.y;
      end else begin
         if (item_ff.z >= cell_rd_ff.hi) begin
            cell_new.hi = item_ff.z;  cell_new.hx = item_ff.x;  cell_new.hy = item_ff.y;
         end
         if (item_ff.z <= cell_rd_ff.lo) cell_new.lo = item_ff.z;
      end

      colw = (QBX+5)'(qx_ff);
      roww = (QBY+5)'(qy_ff);
      rsp_new           = '0;
      rsp_new.in_volume = 1'b1;
      rsp_new.col       = colw[4:0];
      rsp_new.row       = roww[4:0];
      rsp_new.top       = cell_new.hi;
      rsp_new.bottom    = cell_new.lo;
      rsp_new.top_x     = cell_new.hx;
      rsp_new.top_y     = cell_new.hy;
      if (item_ff.kind == KIND_SCAN) begin
         rsp_new.sector  = sec_idx;
         rsp_new.updated = sec_upd;
         rsp_new.nearest = new_dist;
      end

      cell_we    = 1'b0;
      cell_waddr = cell_addr;
      cell_wdata = cell_new;
      if (state_ff == ST_SWEEP) begin
         cell_we    = 1'b1;
         cell_waddr = sweep_ff;
         cell_wdata = '0;
      end else if (state_ff == ST_WRITE && proceed) begin
         cell_we = 1'b1;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      q_pop    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               case (q_item.kind)
                  KIND_CLEAR: state_in = ST_SWEEP;
                  KIND_SKIP:  state_in = ST_ZERO;
                  default:    state_in = ST_SQX;
               endcase
            end
         end
         ST_SWEEP: if (last_sweep) state_in = init_ff ? ST_IDLE : ST_ZERO;
         ST_SQX:   state_in = ST_SQY;
         ST_SQY:   state_in = ST_CALC;
         ST_CALC:  if (step_ff == 5'(CALC_STEPS - 1)) state_in = ST_READ;
         ST_READ:  state_in = ST_WRITE;
         ST_WRITE: if (proceed) state_in = ST_IDLE;
         ST_ZERO:  if (proceed) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         init_ff      <= 1'b1;
         sweep_ff     <= '0;
         sec_valid_ff <= '0;
         fill_ff      <= MAX_RANGE_RST;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_SWEEP) begin
            sweep_ff <= sweep_ff + CAW'(1);
            if (last_sweep) init_ff <= 1'b0;
         end
         if (q_pop && q_item.kind == KIND_CLEAR) begin
            sec_valid_ff <= '0;
            fill_ff      <= cfg.max_range;
            sweep_ff     <= '0;
         end
         if (state_ff == ST_WRITE && proceed && item_ff.kind == KIND_SCAN)
            sec_valid_ff[sec_idx] <= 1'b1;
         if ((state_ff == ST_WRITE || state_ff == ST_ZERO) && proceed)
            out_valid_ff <= 1'b1;
         else if (out_pop)
            out_valid_ff <= 1'b0;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (q_pop) item_ff <= q_item;
      case (state_ff)
         ST_SQX: begin
            prod_ff  <= SQ_W'(ax) * SQ_W'(ax);
            remx_ff  <= NXW'(xr[COORD_W-1:0]) * NXW'(GRID_X);
            remy_ff  <= NYW'(yr[COORD_W-1:0]) * NYW'(GRID_Y);
            dsx_ff   <= NXW'({cfg.max_range, 1'b0}) << (QBX - 1);
            dsy_ff   <= NYW'({cfg.max_range, 1'b0}) << (QBY - 1);
            qx_ff    <= '0;
            qy_ff    <= '0;
            lower_ff <= (qb <= qa);
            eq_ff    <= (qb == qa);
            num_ff   <= (qb <= qa) ? qb : qa;
            den_ff   <= (qb <= qa) ? qa : qb;
            base_ff  <= qbase;
            origin_ff <= (item_ff.x == '0) && (item_ff.y == '0);
            negax_ff  <= (item_ff.y == '0) && (item_ff.x < 0);
            cnt_ff   <= '0;
            step_ff  <= '0;
         end
         ST_SQY: begin
            sq_ff  <= prod_ff + SQ_W'(ay) * SQ_W'(ay);
            n_ff   <= prod_ff + SQ_W'(ay) * SQ_W'(ay);
            r_ff   <= '0;
            bit_ff <= SQ_W'(1) << (SQ_W - 2);
         end
         ST_CALC: begin
            step_ff <= step_ff + 5'd1;
            // one root bit per step
            if (n_ff >= rb) begin
               n_ff <= n_ff - rb;
               r_ff <= (r_ff >> 1) + bit_ff;
            end else begin
               r_ff <= r_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
            // tangent boundaries: product now, compare next step
            if (step_ff < 5'(TAN_N))
               tprod_ff <= SQ_W'(den_ff) * SQ_W'(tan_lut(step_ff[3:0]));
            if (step_ff >= 5'd1 && step_ff <= 5'(TAN_N) &&
                (SQ_W'(num_ff) << TAN_SHIFT) >= tprod_ff)
               cnt_ff <= cnt_ff + 4'd1;
            // restoring division, one quotient bit per step
            if (step_ff < 5'(QBX)) begin
               if (remx_ff >= dsx_ff) remx_ff <= remx_ff - dsx_ff;
               qx_ff  <= QBX'({qx_ff, remx_ff >= dsx_ff});
               dsx_ff <= dsx_ff >> 1;
            end
            if (step_ff < 5'(QBY)) begin
               if (remy_ff >= dsy_ff) remy_ff <= remy_ff - dsy_ff;
               qy_ff  <= QBY'({qy_ff, remy_ff >= dsy_ff});
               dsy_ff <= dsy_ff >> 1;
            end
         end
         ST_WRITE: if (proceed) out_ff <= rsp_new;
         ST_ZERO:  if (proceed) out_ff <= '0;
         default: ;
      endcase
   end

   // grid and sector memories, registered reads
   always_ff @(posedge clock) begin
      if (cell_we) cell_mem[cell_waddr] <= cell_wdata;
      cell_rd_ff <= cell_mem[cell_addr];
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_WRITE && proceed && item_ff.kind == KIND_SCAN)
         sec_mem[sec_idx] <= new_dist;
      sec_rd_ff <= sec_mem[sec_idx];
   end

   assign init_busy = init_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

endmodule

@@ hdl/point_grid_height_binning.sv @@
// Top level of the point grid height binning block: registers, front and back.
//
//  channel  ports     transfer when          payload
//  req      push/full push & !full            operation, point x/y/z
//  rsp      empty/pop pop & !empty            cell, sector and height fields
//  csr      we        we                      index, wdata
//
// A point in the back end runs ST_SQX, ST_SQY, the 20-step square root loop
// (which also covers the cell index division and the 14 sector boundary
// tests), ST_READ and ST_WRITE. A clear sweeps one grid cell per cycle and
// then gives a zero result; after reset the same sweep runs with req_full high.
// The two-entry queue keeps taking items while a result waits on rsp.
module point_grid_height_binning #(
   parameter int GRID_X = 32,
   parameter int GRID_Y = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [1:0]                          req_operation,
   input  logic signed [pgb_pkg::COORD_W-1:0]  req_point_x,
   input  logic signed [pgb_pkg::COORD_W-1:0]  req_point_y,
   input  logic signed [pgb_pkg::COORD_W-1:0]  req_point_z,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic                                rsp_in_volume,
   output logic [4:0]                          rsp_cell_col,
   output logic [4:0]                          rsp_cell_row,
   output logic [pgb_pkg::SECT_AW-1:0]         rsp_sector_index,
   output logic                                rsp_sector_updated,
   output logic signed [pgb_pkg::COORD_W-1:0]  rsp_cell_top,
   output logic signed [pgb_pkg::COORD_W-1:0]  rsp_cell_bottom,
   output logic signed [pgb_pkg::COORD_W-1:0]  rsp_top_point_x,
   output logic signed [pgb_pkg::COORD_W-1:0]  rsp_top_point_y,
   output logic [pgb_pkg::RANGE_W-1:0]         rsp_sector_nearest,
   input  logic                                csr_we,
   input  logic [1:0]                          csr_index,
   input  logic [pgb_pkg::COORD_W-1:0]         csr_wdata
);
   import pgb_pkg::*;

   cfg_type  cfg_ff;
   item_type q_item;
   rsp_type  out_data;
   logic     q_valid, q_pop, init_busy, front_full, out_valid, out_pop, push_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_range <= MAX_RANGE_RST;
         cfg_ff.ceiling   <= CEILING_RST;
         cfg_ff.floor_h   <= FLOOR_RST;
         cfg_ff.object_h  <= OBJECT_RST;
      end else if (csr_we) begin
         case (csr_type'(csr_index))
            CSR_MAX_RANGE: cfg_ff.max_range <= csr_wdata[RANGE_W-1:0];
            CSR_CEILING:   cfg_ff.ceiling   <= $signed(csr_wdata);
            CSR_FLOOR:     cfg_ff.floor_h   <= $signed(csr_wdata);
            CSR_OBJECT:    cfg_ff.object_h  <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   assign req_full = front_full || init_busy;
   assign push_ok  = req_push && !init_busy;
   assign out_pop  = rsp_pop && out_valid;

   pgb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push_ok),
      .full      (front_full),
      .cfg       (cfg_ff),
      .operation (req_operation),
      .x         (req_point_x),
      .y         (req_point_y),
      .z         (req_point_z),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   pgb_back #(
      .GRID_X (GRID_X),
      .GRID_Y (GRID_Y)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .init_busy (init_busy),
      .out_valid (out_valid),
      .out_data  (out_data),
      .out_pop   (out_pop)
   );

   assign rsp_empty          = !out_valid;
   assign rsp_in_volume      = out_data.in_volume;
   assign rsp_cell_col       = out_data.col;
   assign rsp_cell_row       = out_data.row;
   assign rsp_sector_index   = out_data.sector;
   assign rsp_sector_updated = out_data.updated;
   assign rsp_cell_top       = out_data.top;
   assign rsp_cell_bottom    = out_data.bottom;
   assign rsp_top_point_x    = out_data.top_x;
   assign rsp_top_point_y    = out_data.top_y;
   assign rsp_sector_nearest = out_data.nearest;

endmodule

@@ hdl/pgb_checker.sv @@
// Port-level checks for the point grid height binning block, bound to the top.
module pgb_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_push,
   input logic                                req_full,
   input logic                                rsp_empty,
   input logic                                rsp_pop,
   input logic                                rsp_in_volume,
   input logic [4:0]                          rsp_cell_col,
   input logic [pgb_pkg::SECT_AW-1:0]         rsp_sector_index,
   input logic                                rsp_sector_updated,
   input logic signed [pgb_pkg::COORD_W-1:0]  rsp_cell_top,
   input logic [pgb_pkg::RANGE_W-1:0]         rsp_sector_nearest
);
   import pgb_pkg::*;

   // reset starts the grid sweep, so nothing is taken or shown right after it
   a_reset_state: assert property (@(posedge clock)
      reset |=> req_full && rsp_empty)
      else $error("block not quiet after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_cell_top))
      else $error("result changed before transfer");

   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_in_volume |->
         rsp_cell_col == 5'd0 && !rsp_sector_updated && rsp_sector_nearest == '0)
      else $error("unbinned result not zero");

   // a lowered sector is only ever from a binned point beyond the near limit
   a_update: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_sector_updated |->
         rsp_in_volume && rsp_sector_nearest >= 19'd512 && rsp_sector_index <= SECT_LAST)
      else $error("bad sector update");

endmodule

bind point_grid_height_binning pgb_checker u_pgb_checker (.*);

@@ tb/tb.sv @@
// Testbench for the point grid height binning block: directed, config and random tests.
`timescale 1ns / 1ps

module tb;
   import pgb_pkg::*;

   logic clock;
   logic reset;
   logic req_push;
   logic req_full;
   logic [1:0] req_operation;
   logic signed [COORD_W-1:0] req_point_x;
   logic signed [COORD_W-1:0] req_point_y;
   logic signed [COORD_W-1:0] req_point_z;
   logic rsp_empty;
   logic rsp_pop;
   logic rsp_in_volume;
   logic [4:0] rsp_cell_col;
   logic [4:0] rsp_cell_row;
   logic [SECT_AW-1:0] rsp_sector_index;
   logic rsp_sector_updated;
   logic signed [COORD_W-1:0] rsp_cell_top;
   logic signed [COORD_W-1:0] rsp_cell_bottom;
   logic signed [COORD_W-1:0] rsp_top_point_x;
   logic signed [COORD_W-1:0] rsp_top_point_y;
   logic [RANGE_W-1:0] rsp_sector_nearest;
   logic csr_we;
   logic [1:0] csr_index;
   logic [COORD_W-1:0] csr_wdata;

   point_grid_height_binning u_dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_operation(req_operation),
      .req_point_x(req_point_x), .req_point_y(req_point_y), .req_point_z(req_point_z),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_in_volume(rsp_in_volume),
      .rsp_cell_col(rsp_cell_col), .rsp_cell_row(rsp_cell_row),
      .rsp_sector_index(rsp_sector_index), .rsp_sector_updated(rsp_sector_updated),
      .rsp_cell_top(rsp_cell_top), .rsp_cell_bottom(rsp_cell_bottom),
      .rsp_top_point_x(rsp_top_point_x), .rsp_top_point_y(rsp_top_point_y),
      .rsp_sector_nearest(rsp_sector_nearest),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   localparam int NCELL = 2048;
   localparam longint NEAR_LIM = 262144;
   localparam longint TAN_SCALED [14] = '{54953, 110210, 166078, 222882, 280965, 340703,
      402511, 466856, 534276, 605396, 680953, 761835, 849120, 944142};

   // predictor state
   longint rng_cfg, ceil_cfg, floor_cfg, obj_cfg;
   bit     occ [NCELL];
   longint hi_z [NCELL];
   longint lo_z [NCELL];
   longint hi_x [NCELL];
   longint hi_y [NCELL];
   longint sect_near [SECT_N];

   rsp_type expected_rsp [$];
   int errors = 0;
   int n_binned = 0, n_lowered = 0, n_clears = 0, n_items = 0;
   int send_idle = 0, recv_idle = 0;
   int hold_req = 0, hold_seen = 0, hold_cnt = 0;

   initial clock = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   initial begin
      #50ms;
      $display("tb NOT OK");
      $finish;
   end

   function automatic longint int_sqrt(longint unsigned n);
      longint unsigned r = 0, b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return longint'(r);
   endfunction

   function automatic int quadrant_sector(longint a, longint b);
      int cnt = 0;
      if (b <= a) begin
         for (int j = 0; j < 14; j++) if ((b << 20) >= a * TAN_SCALED[j]) cnt++;
         if (b == a) cnt++;
         return cnt;
      end
      for (int j = 0; j < 14; j++) if ((a << 20) >= b * TAN_SCALED[j]) cnt++;
      return 29 - cnt;
   endfunction

   // yaw sector of atan2(y,x)+180, worked on the mirrored point
   function automatic int yaw_sector(longint x, longint y);
      longint u = -x, v = -y;
      int s;
      if (x == 0 && y == 0) return 60;
      if (y == 0 && x < 0) return 119;
      if (u > 0 && v >= 0) s = quadrant_sector(u, v);
      else if (u <= 0 && v > 0) s = 30 + quadrant_sector(v, -u);
      else if (u < 0 && v <= 0) s = 60 + quadrant_sector(-u, -v);
      else s = 90 + quadrant_sector(-v, u);
      return (s > 119) ? 119 : s;
   endfunction

   function automatic void clear_grids();
      foreach (occ[i]) occ[i] = 0;
      foreach (sect_near[i]) sect_near[i] = rng_cfg;
   endfunction

   function automatic void predict_bin(op_type op, longint x, longint y, longint z);
      rsp_type e;
      longint col, row, sq, d;
      int c, s;
      e = '0;
      n_items++;
      if (op == OP_CLEAR) begin
         clear_grids();
         n_clears++;
      end else if (op != OP_NONE && z < ceil_cfg && z > floor_cfg && x < rng_cfg
                   && -x < rng_cfg && y < rng_cfg && -y < rng_cfg) begin
         col = ((x + rng_cfg) * 32) / (2 * rng_cfg);
         row = ((y + rng_cfg) * 32) / (2 * rng_cfg);
         if (col > 31) col = 31;
         if (row > 31) row = 31;
         c = ((op == OP_MAP) ? 1024 : 0) + int'(col) * 32 + int'(row);
         if (!occ[c]) begin
            occ[c] = 1;
            hi_z[c] = z; lo_z[c] = z; hi_x[c] = x; hi_y[c] = y;
         end else begin
            if (z >= hi_z[c]) begin
               hi_z[c] = z; hi_x[c] = x; hi_y[c] = y;
            end
            if (z <= lo_z[c]) lo_z[c] = z;
         end
         n_binned++;
         e.in_volume = 1;
         e.col = col[4:0];
         e.row = row[4:0];
         e.top = hi_z[c][19:0];
         e.bottom = lo_z[c][19:0];
         e.top_x = hi_x[c][19:0];
         e.top_y = hi_y[c][19:0];
         if (op == OP_SCAN) begin
            s = yaw_sector(x, y);
            sq = x * x + y * y;
            if (z >= obj_cfg && sq > NEAR_LIM) begin
               d = int_sqrt(sq);
               if (d < sect_near[s]) begin
                  sect_near[s] = d;
                  e.updated = 1;
                  n_lowered++;
               end
            end
            e.sector = s[6:0];
            e.nearest = sect_near[s][18:0];
         end
      end
      expected_rsp.insert(expected_rsp.size(), e);
   endfunction

   task automatic send_item(op_type op, longint x, longint y, longint z);
      if (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_push <= 0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req_push <= 1;
      req_operation <= op;
      req_point_x <= x[19:0];
      req_point_y <= y[19:0];
      req_point_z <= z[19:0];
      do @(posedge clock); while (req_full);
      predict_bin(op, x, y, z);
   endtask

   // wait out every pending result, including the zero result ending a clear sweep
   task automatic drain();
      req_push <= 0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(csr_type idx, longint val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val[19:0];
      @(posedge clock);
      csr_we <= 0;
      case (idx)
         CSR_MAX_RANGE: rng_cfg = longint'(val[18:0]);
         CSR_CEILING:   ceil_cfg = longint'($signed(val[19:0]));
         CSR_FLOOR:     floor_cfg = longint'($signed(val[19:0]));
         CSR_OBJECT:    obj_cfg = longint'($signed(val[19:0]));
         default: ;
      endcase
   endtask

   function automatic longint pick(longint lo, longint hi);
      if (hi < lo) return lo;
      return lo + longint'($urandom % (hi - lo + 1));
   endfunction

   function automatic void check_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s mismatch expected %0d actual %0d", $time, name, exp_v, act_v);
         errors++;
      end
   endfunction

   // receiver: random pops, long hold-offs on request, field checks
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         rsp_pop <= 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t: unexpected result transfer", $time);
               errors++;
            end else begin
               e = expected_rsp.pop_front();
               check_field("in_volume", e.in_volume, rsp_in_volume);
               check_field("cell_col", e.col, rsp_cell_col);
               check_field("cell_row", e.row, rsp_cell_row);
               check_field("sector_index", e.sector, rsp_sector_index);
               check_field("sector_updated", e.updated, rsp_sector_updated);
               check_field("cell_top", e.top, rsp_cell_top);
               check_field("cell_bottom", e.bottom, rsp_cell_bottom);
               check_field("top_point_x", e.top_x, rsp_top_point_x);
               check_field("top_point_y", e.top_y, rsp_top_point_y);
               check_field("sector_nearest", e.nearest, rsp_sector_nearest);
            end
         end
         if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_cnt = 400;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_pop <= 0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   task automatic test_directed();
      send_item(OP_CLEAR, 0, 0, 0);
      send_item(OP_SCAN, -3000, 0, 200);      // negative x axis: last sector
      send_item(OP_SCAN, 0, 0, 200);          // origin
      send_item(OP_SCAN, -1000, -1000, 300);  // exact 45 degrees
      send_item(OP_SCAN, 1000, 1000, 300);
      send_item(OP_SCAN, 512, 0, 300);        // exactly 2 m: no update
      send_item(OP_SCAN, 513, 0, 300);
      send_item(OP_SCAN, 900, 0, 300);        // farther, same sector
      send_item(OP_SCAN, 600, 10, 100);       // below object height
      send_item(OP_MAP, 5000, -7000, 100);
      send_item(OP_MAP, 5001, -7001, 100);    // tie: later point wins
      send_item(OP_MAP, 5002, -7002, -300);
      send_item(OP_MAP, 5003, -7003, 700);
      send_item(OP_NONE, 100, 100, 0);
      send_item(OP_SCAN, 100, 100, 768);      // at ceiling
      send_item(OP_SCAN, 100, 100, -512);     // at floor
      send_item(OP_SCAN, 20479, -20479, 767);
      send_item(OP_SCAN, -20479, 20479, -511);
      send_item(OP_SCAN, 20480, 0, 0);
      send_item(OP_MAP, 0, -20480, 0);
      send_item(OP_SCAN, 524287, -524288, 524287);
      send_item(OP_MAP, -524288, 524287, -524288);
      send_item(OP_SCAN, 0, 4000, 400);
      send_item(OP_CLEAR, 0, 0, 0);
      send_item(OP_SCAN, 0, -4000, 400);
      drain();
   endtask

   task automatic random_item();
      int sel;
      longint r;
      op_type op;
      sel = $urandom_range(99);
      r = rng_cfg;
      op = ($urandom_range(1) == 1) ? OP_SCAN : OP_MAP;
      if (sel < 2) begin
         send_item(OP_CLEAR, pick(-524288, 524287), pick(-524288, 524287), 0);
      end else if (sel < 6) begin
         send_item(OP_NONE, pick(-524288, 524287), pick(-524288, 524287),
                   pick(-524288, 524287));
      end else if (sel < 14) begin
         send_item(op, pick(-524288, 524287), pick(-524288, 524287),
                   pick(-524288, 524287));
      end else if (sel < 30) begin
         // small cluster so cells get revisited and ties happen
         send_item(op, pick(-300, 300) * (r / 600), pick(-2, 2) * (r / 600),
                   pick(floor_cfg + 1, floor_cfg + 8));
      end else begin
         send_item(op, pick(1 - r, r - 1), pick(1 - r, r - 1),
                   pick(floor_cfg + 1, ceil_cfg - 1));
      end
   endtask

   task automatic test_random(int count);
      repeat (count) random_item();
      drain();
   endtask

   task automatic test_config_extremes();
      write_reg(CSR_MAX_RANGE, 1);
      send_item(OP_SCAN, 0, 0, 0);
      send_item(OP_MAP, 1, 0, 0);
      send_item(OP_CLEAR, 0, 0, 0);
      send_item(OP_SCAN, 0, 0, 500);
      drain();
      write_reg(CSR_MAX_RANGE, 524287);
      write_reg(CSR_CEILING, 524287);
      write_reg(CSR_FLOOR, -524288);
      write_reg(CSR_OBJECT, -524288);
      send_item(OP_CLEAR, 0, 0, 0);
      send_item(OP_SCAN, 524286, -524286, 524286);
      send_item(OP_SCAN, -524286, 524286, -524287);
      test_random(30);
      write_reg(CSR_CEILING, -524288);
      write_reg(CSR_OBJECT, 524287);
      test_random(10);
      write_reg(CSR_MAX_RANGE, 3000);
      write_reg(CSR_CEILING, 2000);
      write_reg(CSR_FLOOR, -100);
      write_reg(CSR_OBJECT, 0);
      send_item(OP_CLEAR, 0, 0, 0);
      test_random(40);
      write_reg(CSR_MAX_RANGE, 20480);
      write_reg(CSR_CEILING, 768);
      write_reg(CSR_FLOOR, -512);
      write_reg(CSR_OBJECT, 128);
   endtask

   task automatic test_backpressure();
      send_idle = 0;
      hold_req++;
      repeat (25) random_item();
      drain();
   endtask

   task automatic test_sender_pause();
      repeat (15) random_item();
      req_push <= 0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (15) random_item();
      drain();
   endtask

   initial begin
      reset = 1;
      req_push <= 0;
      req_operation <= OP_CLEAR;
      req_point_x <= '0;
      req_point_y <= '0;
      req_point_z <= '0;
      csr_we <= 0;
      csr_index <= CSR_MAX_RANGE;
      csr_wdata <= '0;
      rng_cfg = 20480; ceil_cfg = 768; floor_cfg = -512; obj_cfg = 128;
      clear_grids();
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_idle = 34; recv_idle = 59;
      test_directed();
      test_config_extremes();
      test_random(90);
      send_idle = 59; recv_idle = 34;
      test_random(90);
      test_backpressure();
      send_idle = 0; recv_idle = 0;
      test_sender_pause();
      test_random(60);

      if (expected_rsp.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, expected_rsp.size());
         errors++;
      end
      $display("Covered %0d items: %0d binned, %0d sector lowerings, %0d clears,",
               n_items, n_binned, n_lowered, n_clears);
      $display("register extremes, long result hold-off and sender pause; errors %0d",
               errors);
      if (errors == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule
